### hw/rtl/icfp_pkg.sv
// ----------------------------------------------------------------------------
// icfp_pkg
// Types, constants and the divider step function for the command frame packer.
// ----------------------------------------------------------------------------
package icfp_pkg;

  localparam int POS_BITS    = 16;
  localparam int OTHER_BITS  = 12;
  localparam int DIV_STAGES  = POS_BITS + 1;
  localparam int SHORT_START = POS_BITS - OTHER_BITS;
  localparam int LATENCY     = DIV_STAGES + 3;

  localparam logic [10:0] FRAME_BASE = 11'h400;

  localparam logic [7:0] REG_POSITION  = 8'd0;
  localparam logic [7:0] REG_VELOCITY  = 8'd1;
  localparam logic [7:0] REG_TORQUE    = 8'd2;
  localparam logic [7:0] REG_STIFFNESS = 8'd3;
  localparam logic [7:0] REG_DAMPING   = 8'd4;

  localparam logic [30:0] RESET_POSITION  = 31'd823132;
  localparam logic [30:0] RESET_VELOCITY  = 31'd3932160;
  localparam logic [30:0] RESET_TORQUE    = 31'd786432;
  localparam logic [30:0] RESET_STIFFNESS = 31'd32768000;
  localparam logic [30:0] RESET_DAMPING   = 31'd327680;

  typedef struct packed {
    logic [7:0]         motor_number;
    logic signed [31:0] position_target;
    logic signed [31:0] velocity_target;
    logic signed [31:0] stiffness_gain;
    logic signed [31:0] damping_gain;
    logic signed [31:0] feedforward_torque;
  } command_t;

  typedef struct packed {
    logic [10:0]        frame_id;
    logic [7:0]         byte0;
    logic [7:0]         byte1;
    logic [7:0]         byte2;
    logic [7:0]         byte3;
    logic [7:0]         byte4;
    logic [7:0]         byte5;
    logic [7:0]         byte6;
    logic [7:0]         byte7;
    logic [30:0]        clamped_stiffness;
    logic [30:0]        clamped_damping;
    logic signed [31:0] clamped_torque;
  } result_t;

  typedef struct packed {
    logic [30:0] position;
    logic [30:0] velocity;
    logic [30:0] torque;
    logic [30:0] stiffness;
    logic [30:0] damping;
  } limits_t;

  typedef struct packed {
    logic [32:0]            rem;
    logic [DIV_STAGES-1:0]  quo;
    logic [31:0]            span;
    logic signed [31:0]     clamped;
  } div_lane_t;

  // One restoring division step; the first active step takes the numerator unshifted.
  function automatic div_lane_t div_step(input div_lane_t d, input logic active,
                                         input logic first);
    div_lane_t  o;
    logic [32:0] t;
    logic        ge;
    o  = d;
    t  = first ? d.rem : {d.rem[31:0], 1'b0};
    ge = (t >= {1'b0, d.span});
    if (active) begin
      o.rem = ge ? (t - {1'b0, d.span}) : t;
      o.quo = {d.quo[DIV_STAGES-2:0], ge};
    end
    return o;
  endfunction

endpackage

### hw/rtl/icfp_cfg.sv
// ----------------------------------------------------------------------------
// icfp_cfg
// Limit register file, written through the configuration channel.
// ----------------------------------------------------------------------------
module icfp_cfg (
  input  logic             clk,
  input  logic             rst,
  input  logic             cfg_valid,
  input  logic [7:0]       cfg_index,
  input  logic [31:0]      cfg_data,
  output icfp_pkg::limits_t limits
);
  import icfp_pkg::*;

  always_ff @(posedge clk) begin
    if (rst) begin
      limits.position  <= RESET_POSITION;
      limits.velocity  <= RESET_VELOCITY;
      limits.torque    <= RESET_TORQUE;
      limits.stiffness <= RESET_STIFFNESS;
      limits.damping   <= RESET_DAMPING;
    end else if (cfg_valid) begin
      case (cfg_index)
        REG_POSITION:  limits.position  <= cfg_data[30:0];
        REG_VELOCITY:  limits.velocity  <= cfg_data[30:0];
        REG_TORQUE:    limits.torque    <= cfg_data[30:0];
        REG_STIFFNESS: limits.stiffness <= cfg_data[30:0];
        REG_DAMPING:   limits.damping   <= cfg_data[30:0];
        default: ; // drop writes to unknown indexes
      endcase
    end
  end

endmodule

### hw/rtl/icfp_lane.sv
// ----------------------------------------------------------------------------
// icfp_lane
// Clamp, offset and pipelined restoring division of one set-point to its code.
// ----------------------------------------------------------------------------
module icfp_lane (
  input  logic               clk,
  input  logic signed [31:0] x,
  input  logic [30:0]        limit,
  input  logic               sym,
  input  logic               long_code,
  output logic [15:0]        code,
  output logic signed [31:0] clamped
);
  import icfp_pkg::*;

  logic signed [32:0] lim_w;
  logic signed [32:0] lo_w;
  logic signed [32:0] x_w;
  logic signed [32:0] c_w;
  logic [31:0]        span_w;

  logic signed [32:0] s1_c;
  logic signed [32:0] s1_lo;
  logic [31:0]        s1_span;
  logic [32:0]        num_w;

  div_lane_t stage [0:DIV_STAGES];
  div_lane_t last;

  always_comb begin
    lim_w  = $signed({2'b00, limit});
    lo_w   = sym ? -lim_w : 33'sd0;
    x_w    = $signed({x[31], x});
    if (x_w < lo_w) begin
      c_w = lo_w;
    end else if (x_w > lim_w) begin
      c_w = lim_w;
    end else begin
      c_w = x_w;
    end
    span_w = sym ? {limit, 1'b0} : {1'b0, limit};
  end

  always_ff @(posedge clk) begin
    s1_c    <= c_w;
    s1_lo   <= lo_w;
    s1_span <= span_w;
  end

  assign num_w = 33'(s1_c - s1_lo);

  always_ff @(posedge clk) begin
    stage[0].rem     <= {1'b0, num_w[31:0]};
    stage[0].quo     <= '0;
    stage[0].span    <= s1_span;
    stage[0].clamped <= s1_c[31:0];
  end

  for (genvar s = 0; s < DIV_STAGES; s++) begin : g_div
    logic active;
    logic first;
    assign active = long_code || (s >= SHORT_START);
    assign first  = long_code ? (s == 0) : (s == SHORT_START);
    always_ff @(posedge clk) begin
      stage[s+1] <= div_step(stage[s], active, first);
    end
  end

  assign last = stage[DIV_STAGES];

  // Saturate a quotient of exactly 2^bits; a zero span yields code zero.
  always_ff @(posedge clk) begin
    if (last.span == '0) begin
      code <= '0;
    end else if (long_code) begin
      code <= last.quo[POS_BITS] ? '1 : last.quo[POS_BITS-1:0];
    end else begin
      code <= last.quo[OTHER_BITS] ? {{(POS_BITS-OTHER_BITS){1'b0}}, {OTHER_BITS{1'b1}}}
                                   : {{(POS_BITS-OTHER_BITS){1'b0}}, last.quo[OTHER_BITS-1:0]};
    end
    clamped <= last.clamped;
  end

endmodule

### hw/rtl/impedance_command_frame_packer.sv
// ----------------------------------------------------------------------------
// impedance_command_frame_packer
// Clamps five set-points, scales them to codes and packs an 8-byte CAN frame.
// ----------------------------------------------------------------------------
// Pipeline: clamp, offset, 17 divider stages and code saturation, each registered,
// from start to result_strobe. Throughput: one command per cycle while busy is low.
// The 17 one-bit restoring divider stages set the depth; the receiver cannot stall.
// Reset: synchronous; clears valid bits and restores the default limits.
module impedance_command_frame_packer (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  output logic               busy,
  input  icfp_pkg::command_t command,
  output logic               result_strobe,
  output icfp_pkg::result_t  result,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [7:0]         cfg_index,
  input  logic [31:0]        cfg_data
);
  import icfp_pkg::*;

  limits_t             limits;
  logic                accept;
  logic [LATENCY-1:0]  vpipe;
  logic [7:0]          motor [0:LATENCY-1];
  logic [15:0]         pc, vc, kpc, kdc, tc;
  logic signed [31:0]  pcl, vcl, kpcl, kdcl, tcl;

  assign cfg_ready = 1'b1;
  assign accept    = start && !busy;

  always_ff @(posedge clk) begin
    busy <= rst;
  end

  icfp_cfg u_cfg (
    .clk, .rst, .cfg_valid(cfg_valid && cfg_ready), .cfg_index, .cfg_data, .limits
  );

  icfp_lane u_pos (.clk, .x(command.position_target), .limit(limits.position),
    .sym(1'b1), .long_code(1'b1), .code(pc), .clamped(pcl));
  icfp_lane u_vel (.clk, .x(command.velocity_target), .limit(limits.velocity),
    .sym(1'b1), .long_code(1'b0), .code(vc), .clamped(vcl));
  icfp_lane u_kp (.clk, .x(command.stiffness_gain), .limit(limits.stiffness),
    .sym(1'b0), .long_code(1'b0), .code(kpc), .clamped(kpcl));
  icfp_lane u_kd (.clk, .x(command.damping_gain), .limit(limits.damping),
    .sym(1'b0), .long_code(1'b0), .code(kdc), .clamped(kdcl));
  icfp_lane u_tq (.clk, .x(command.feedforward_torque), .limit(limits.torque),
    .sym(1'b1), .long_code(1'b0), .code(tc), .clamped(tcl));

  always_ff @(posedge clk) begin
    if (rst) begin
      vpipe <= '0;
    end else begin
      vpipe <= {vpipe[LATENCY-2:0], accept};
    end
  end

  always_ff @(posedge clk) begin
    motor[0] <= command.motor_number;
    for (int i = 1; i < LATENCY; i++) begin
      motor[i] <= motor[i-1];
    end
  end

  assign result_strobe = vpipe[LATENCY-1];

  always_comb begin
    result.frame_id          = FRAME_BASE + {3'b000, motor[LATENCY-1]};
    result.byte0             = pc[15:8];
    result.byte1             = pc[7:0];
    result.byte2             = vc[11:4];
    result.byte3             = {vc[3:0], kpc[11:8]};
    result.byte4             = kpc[7:0];
    result.byte5             = kdc[11:4];
    result.byte6             = {kdc[3:0], tc[11:8]};
    result.byte7             = tc[7:0];
    result.clamped_stiffness = kpcl[30:0];
    result.clamped_damping   = kdcl[30:0];
    result.clamped_torque    = tcl;
  end

  // pcl and vcl feed no port; they only keep the lanes uniform
  logic unused_clamped;
  assign unused_clamped = ^{pcl, vcl, pc[15:12] & 4'h0, vc[15:12], kpc[15:12],
                            kdc[15:12], tc[15:12], kpcl[31], kdcl[31]};

  a_strobe_follows_start: assert property (@(posedge clk) disable iff (rst)
    result_strobe |-> $past(accept, LATENCY))
    else $error("result without a matching command");

  a_frame_base: assert property (@(posedge clk) disable iff (rst)
    result_strobe |-> (result.frame_id[10:8] == 3'b100))
    else $error("frame identifier outside base range");

  a_gain_clamped: assert property (@(posedge clk) disable iff (rst)
    result_strobe |-> (result.clamped_stiffness <= limits.stiffness &&
                       result.clamped_damping <= limits.damping))
    else $error("gain above its limit");

endmodule

### tb/impedance_command_frame_packer_tb.sv
// ----------------------------------------------------------------------------
// impedance_command_frame_packer_tb
// Drives motor commands through the frame packer under several limit settings.
// Every frame is checked field by field, against a predictor of the clamping,
// scaling and byte packing or, for a few directed rows, a hand-written frame.
// ----------------------------------------------------------------------------
module impedance_command_frame_packer_tb;
  import icfp_pkg::*;

  localparam int CYCLE_LIMIT = 400000;
  localparam int PHASE_ITEMS = 200;

  logic                clk = 1'b0;
  logic                rst = 1'b1;
  logic                start = 1'b0;
  logic                busy;
  command_t            command = '0;
  logic                result_strobe;
  result_t             result;
  logic                cfg_valid = 1'b0;
  logic                cfg_ready;
  logic [7:0]          cfg_index = '0;
  logic [31:0]         cfg_data = '0;

  limits_t             limits;
  result_t             frame_q[$];
  int                  errors = 0;
  int                  cycles = 0;
  int                  burst_left = 0;

  // directed rows
  command_t            row_cmd[$];
  result_t             row_frame[$];
  bit                  row_known[$];

  impedance_command_frame_packer DUT (
    .clk(clk), .rst(rst), .start(start), .busy(busy), .command(command),
    .result_strobe(result_strobe), .result(result), .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always #5 clk = ~clk;

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("FAIL impedance_command_frame_packer");
      $finish;
    end
  end

  function automatic longint clamp_to(longint x, longint lo, longint hi);
    if (x < lo) x = lo;
    if (x > hi) x = hi;
    return x;
  endfunction

  function automatic logic [15:0] scale_code(longint x, longint lo, longint span, int bits);
    longint unsigned q;
    longint unsigned top;
    top = (64'd1 << bits) - 1;
    if (span == 0) return '0;
    q = (longint'(x - lo) << bits) / span;
    if (q > top) q = top;   // value at the maximum saturates
    return q[15:0];
  endfunction

  function automatic result_t pack_frame(command_t c, limits_t l);
    result_t r;
    longint pl, vl, tl, kl, dl, p, v, kp, kd, t;
    logic [15:0] pc, vc, kpc, kdc, tc;
    pl = longint'(l.position); vl = longint'(l.velocity); tl = longint'(l.torque);
    kl = longint'(l.stiffness); dl = longint'(l.damping);
    p  = clamp_to(longint'(c.position_target), -pl, pl);
    v  = clamp_to(longint'(c.velocity_target), -vl, vl);
    kp = clamp_to(longint'(c.stiffness_gain), 0, kl);
    kd = clamp_to(longint'(c.damping_gain), 0, dl);
    t  = clamp_to(longint'(c.feedforward_torque), -tl, tl);
    pc  = scale_code(p, -pl, 2 * pl, POS_BITS);
    vc  = scale_code(v, -vl, 2 * vl, OTHER_BITS);
    kpc = scale_code(kp, 0, kl, OTHER_BITS);
    kdc = scale_code(kd, 0, dl, OTHER_BITS);
    tc  = scale_code(t, -tl, 2 * tl, OTHER_BITS);
    r.frame_id = FRAME_BASE + {3'b0, c.motor_number};
    r.byte0 = pc[15:8];
    r.byte1 = pc[7:0];
    r.byte2 = vc[11:4];
    r.byte3 = {vc[3:0], kpc[11:8]};
    r.byte4 = kpc[7:0];
    r.byte5 = kdc[11:4];
    r.byte6 = {kdc[3:0], tc[11:8]};
    r.byte7 = tc[7:0];
    r.clamped_stiffness = kp[30:0];
    r.clamped_damping = kd[30:0];
    r.clamped_torque = t[31:0];
    return r;
  endfunction

  task automatic compare_field(string name, longint unsigned exp, longint unsigned got);
    if (exp !== got) begin
      $error("%s: expected %0h, got %0h", name, exp, got);
      errors++;
    end
  endtask

  always @(posedge clk) begin
    if (!rst && result_strobe) begin
      if (frame_q.size() == 0) begin
        $error("frame with no command outstanding");
        errors++;
      end else begin
        result_t e;
        e = frame_q.pop_front();
        compare_field("frame_id", e.frame_id, result.frame_id);
        compare_field("byte0", e.byte0, result.byte0);
        compare_field("byte1", e.byte1, result.byte1);
        compare_field("byte2", e.byte2, result.byte2);
        compare_field("byte3", e.byte3, result.byte3);
        compare_field("byte4", e.byte4, result.byte4);
        compare_field("byte5", e.byte5, result.byte5);
        compare_field("byte6", e.byte6, result.byte6);
        compare_field("byte7", e.byte7, result.byte7);
        compare_field("clamped_stiffness", e.clamped_stiffness, result.clamped_stiffness);
        compare_field("clamped_damping", e.clamped_damping, result.clamped_damping);
        compare_field("clamped_torque", e.clamped_torque, result.clamped_torque);
      end
    end
  end

  // Random idle gaps between bursts; a zero gap keeps start high.
  task automatic pace_sender();
    int gap;
    if (burst_left > 0) begin
      burst_left--;
      return;
    end
    burst_left = $urandom_range(0, 3) == 0 ? $urandom_range(30, 80) : $urandom_range(1, 12);
    gap = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(1, 8);
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic send_command(command_t c, bit known, result_t typed);
    command <= c;
    start <= 1'b1;
    @(posedge clk);
    while (busy) @(posedge clk);
    frame_q.push_back(known ? typed : pack_frame(c, limits));
  endtask

  task automatic drain();
    start <= 1'b0;
    while (frame_q.size() != 0) @(posedge clk);
    repeat (LATENCY + 4) @(posedge clk);
  endtask

  task automatic write_limit(logic [7:0] idx, logic [31:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    @(posedge clk);
    case (idx)
      REG_POSITION:  limits.position  = data[30:0];
      REG_VELOCITY:  limits.velocity  = data[30:0];
      REG_TORQUE:    limits.torque    = data[30:0];
      REG_STIFFNESS: limits.stiffness = data[30:0];
      REG_DAMPING:   limits.damping   = data[30:0];
      default: ;   // out-of-range index: drop
    endcase
  endtask

  task automatic write_all(logic [31:0] p, logic [31:0] v, logic [31:0] t,
                           logic [31:0] k, logic [31:0] d);
    write_limit(REG_POSITION, p);
    write_limit(REG_VELOCITY, v);
    write_limit(REG_TORQUE, t);
    write_limit(REG_STIFFNESS, k);
    write_limit(REG_DAMPING, d);
  endtask

  // Values around the limit and zero, uniform values within the limit, extremes and full-range noise.
  function automatic logic [31:0] pick_value(logic [30:0] lim);
    longint l;
    l = longint'(lim);
    case ($urandom_range(0, 7))
      0: return $urandom();
      1: return $urandom_range(0, 1) ? 32'h7FFF_FFFF : 32'h8000_0000;
      2: return 32'(l + $signed($urandom_range(0, 8)) - 4);
      3: return 32'(-l + $signed($urandom_range(0, 8)) - 4);
      4: return $signed($urandom_range(0, 16)) - 8;
      default: return l == 0 ? $urandom() : 32'(($urandom() % (2 * l + 1)) - l);
    endcase
  endfunction

  function automatic command_t random_command();
    command_t c;
    c.motor_number = 8'($urandom());
    c.position_target = pick_value(limits.position);
    c.velocity_target = pick_value(limits.velocity);
    c.stiffness_gain = pick_value(limits.stiffness);
    c.damping_gain = pick_value(limits.damping);
    c.feedforward_torque = pick_value(limits.torque);
    return c;
  endfunction

  task automatic add_row(command_t c, bit known, result_t f);
    row_cmd.push_back(c);
    row_known.push_back(known);
    row_frame.push_back(f);
  endtask

  task automatic random_phase();
    repeat (PHASE_ITEMS) begin
      pace_sender();
      send_command(random_command(), 1'b0, '0);
    end
    drain();
  endtask

  initial begin
    command_t c;
    result_t  f;
    limits.position  = RESET_POSITION;
    limits.velocity  = RESET_VELOCITY;
    limits.torque    = RESET_TORQUE;
    limits.stiffness = RESET_STIFFNESS;
    limits.damping   = RESET_DAMPING;

    // all fields at their top: every code saturates
    c = {8'hFF, {5{32'h7FFF_FFFF}}};
    f = {11'h4FF, {8{8'hFF}}, RESET_STIFFNESS, RESET_DAMPING, 32'(RESET_TORQUE)};
    add_row(c, 1'b1, f);
    // all fields at their bottom
    c = {8'h00, {5{32'h8000_0000}}};
    f = {11'h400, 64'h0, 31'd0, 31'd0, -32'(RESET_TORQUE)};
    add_row(c, 1'b1, f);
    // all zero: symmetric ranges land mid-scale
    c = '0;
    f = {11'h400, 64'h8000_8000_0000_0800, 31'd0, 31'd0, 32'd0};
    add_row(c, 1'b1, f);
    // exactly at the limits and one below
    c = {8'h5A, 32'(RESET_POSITION), 32'(RESET_VELOCITY), 32'(RESET_STIFFNESS),
         32'(RESET_DAMPING), 32'(RESET_TORQUE)};
    add_row(c, 1'b0, '0);
    c = {8'hA5, 32'(RESET_POSITION) - 1, 32'(RESET_VELOCITY) - 1,
         32'(RESET_STIFFNESS) - 1, 32'(RESET_DAMPING) - 1, 32'(RESET_TORQUE) - 1};
    add_row(c, 1'b0, '0);
    c = {8'h01, -32'(RESET_POSITION), -32'(RESET_VELOCITY), 32'd1, 32'd1,
         -32'(RESET_TORQUE)};
    add_row(c, 1'b0, '0);
    c = {8'h80, 32'hFFFF_FFFF, 32'h1, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'h0001_0000};
    add_row(c, 1'b0, '0);

    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    for (int i = 0; i < row_cmd.size(); i++) begin
      if (i % 3 == 2) begin
        start <= 1'b0;
        @(posedge clk);
      end
      send_command(row_cmd[i], row_known[i], row_frame[i]);
    end
    drain();
    random_phase();

    // smallest nonzero limits
    write_all(32'd1, 32'd1, 32'd1, 32'd1, 32'd1);
    random_phase();
    // largest limits, some with bit 31 set to be ignored
    write_all(32'hFFFF_FFFF, 32'h7FFF_FFFF, 32'hFFFF_FFFF, 32'h7FFF_FFFF, 32'hFFFF_FFFF);
    random_phase();
    // zero limits collapse each range to a point
    write_all(32'd0, 32'd0, 32'd0, 32'd0, 32'd0);
    random_phase();
    repeat (2) begin
      write_all($urandom(), $urandom_range(1, 4000000), $urandom(),
                $urandom_range(1, 100), $urandom());
      write_limit(8'(REG_DAMPING + $urandom_range(1, 250)), $urandom());
      random_phase();
    end
    write_all({1'b1, RESET_POSITION}, {1'b0, RESET_VELOCITY}, {1'b0, RESET_TORQUE},
              {1'b0, RESET_STIFFNESS}, {1'b0, RESET_DAMPING});
    write_limit(8'hFF, 32'hFFFF_FFFF);
    random_phase();

    if (errors == 0) begin
      $display("PASS impedance_command_frame_packer");
    end else begin
      $display("FAIL impedance_command_frame_packer");
    end
    $finish;
  end

endmodule

### impedance_command_frame_packer.f
hw/rtl/icfp_pkg.sv
hw/rtl/icfp_cfg.sv
hw/rtl/icfp_lane.sv
hw/rtl/impedance_command_frame_packer.sv
tb/impedance_command_frame_packer_tb.sv
